/* design/rafb_pkg.sv */
// ----------------------------------------------------------------------------
// rafb_pkg
// Shared types and constants of the register access frame bridge.
// ----------------------------------------------------------------------------
package rafb_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned HDR_BYTES  = 10;
  localparam int unsigned DATA_BYTES = 4;
  localparam int unsigned BIDX_W     = 4;

  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [15:0]      LEN_OVERHEAD = 16'd7;
  localparam logic [15:0]      WR_LEN_BIAS  = 16'd5;
  localparam int unsigned      WRITE_BIT    = 7;
  localparam int unsigned      AUTOINC_BIT  = 6;
  localparam logic [31:0]      ADDR_STEP    = 32'd4;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READREQ = 2'd1;
  localparam logic [1:0] KIND_BYTE    = 2'd2;

  // one queued command for the back end
  typedef struct packed {
    logic                          is_write;
    logic [HDR_BYTES-1:0][7:0]     bytes;
    logic [BIDX_W-1:0]             nbytes;
    logic                          last;
    logic                          req;
    logic [31:0]                   addr;
    logic [31:0]                   word;
  } cmd_t;

endpackage

/* design/rafb_if.sv */
// ----------------------------------------------------------------------------
// rafb_if
// Valid/ready channels of the register access frame bridge.
// ----------------------------------------------------------------------------
interface rafb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  frame_byte;
  logic        end_of_frame;
  logic [31:0] read_data;

  modport source (output valid, mode, frame_byte, end_of_frame, read_data, input ready);
  modport sink (input valid, mode, frame_byte, end_of_frame, read_data, output ready);
endinterface

interface rafb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] bus_address;
  logic [31:0] write_word;
  logic [7:0]  response_byte;
  logic        last;

  modport source (output valid, result_kind, bus_address, write_word, response_byte, last,
                  input ready);
  modport sink (input valid, result_kind, bus_address, write_word, response_byte, last,
                output ready);
endinterface

/* design/rafb_front.sv */
// ----------------------------------------------------------------------------
// rafb_front
// Accepts frame bytes and read data, tracks the frame and queues commands.
// ----------------------------------------------------------------------------
module rafb_front (
  input  logic          clk,
  input  logic          rst_n,
  rafb_in_if.sink       in_bus,
  input  logic          q_full,
  output logic          push,
  output rafb_pkg::cmd_t push_cmd
);
  import rafb_pkg::*;

  typedef enum logic {PH_RECV, PH_WAIT} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [23:0]        wa_r, wa_nxt;
  logic [15:0]        wl_r, wl_nxt;
  logic [7:0]         hdr_r [HDR_BYTES];

  logic               acc;
  logic [7:0]         hb [HDR_BYTES];
  logic               is_wr;
  logic               ainc;
  logic [31:0]        addr_step;
  logic [15:0]        len16;
  logic [15:0]        wlen;
  logic [15:0]        cnt;
  logic [15:0]        rlen;
  logic [15:0]        wl_dec;
  logic               hdr_wr;

  assign in_bus.ready = !q_full;
  assign acc          = in_bus.valid && in_bus.ready;

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hb[i] = (pos_r == POS_W'(i)) ? in_bus.frame_byte : hdr_r[i];
    end
  end

  assign is_wr     = hb[3][WRITE_BIT];
  assign ainc      = hb[3][AUTOINC_BIT];
  assign addr_step = ainc ? addr_r + ADDR_STEP : addr_r;
  assign len16     = {hb[1], hb[2]};
  assign wlen      = (len16 > WR_LEN_BIAS) ? ((len16 - WR_LEN_BIAS) >> 2) : 16'd0;
  assign cnt       = {hb[8], hb[9]};
  assign rlen      = {cnt[13:0], 2'b00} + LEN_OVERHEAD;
  assign wl_dec    = wl_r - 16'd1;
  assign hdr_wr    = acc && !in_bus.mode && (phase_r == PH_RECV) &&
                     (pos_r < POS_W'(HDR_BYTES));

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    addr_nxt  = addr_r;
    wa_nxt    = wa_r;
    wl_nxt    = wl_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (acc) begin
      if (in_bus.mode) begin
        if (phase_r == PH_WAIT) begin
          push            = 1'b1;
          push_cmd.bytes[0] = in_bus.read_data[31:24];
          push_cmd.bytes[1] = in_bus.read_data[23:16];
          push_cmd.bytes[2] = in_bus.read_data[15:8];
          push_cmd.bytes[3] = in_bus.read_data[7:0];
          push_cmd.nbytes = BIDX_W'(DATA_BYTES);
          push_cmd.last   = (wl_dec == 16'd0);
          push_cmd.req    = (wl_dec != 16'd0);
          push_cmd.addr   = addr_step;
          addr_nxt        = addr_step;
          wl_nxt          = wl_dec;
          if (wl_dec == 16'd0) begin
            phase_nxt = PH_RECV;
          end
        end
      end else if (phase_r == PH_RECV) begin
        if (pos_r == POS_W'(7)) begin
          addr_nxt = {hb[4], hb[5], hb[6], hb[7]};
          wl_nxt   = is_wr ? wlen : 16'd0;
        end else if ((pos_r >= POS_W'(8)) && is_wr && (wl_r != 16'd0)) begin
          if (pos_r[1:0] != 2'd3) begin
            wa_nxt = {wa_r[15:0], in_bus.frame_byte};
          end else begin
            push              = 1'b1;
            push_cmd.is_write = 1'b1;
            push_cmd.addr     = addr_r;
            push_cmd.word     = {wa_r, in_bus.frame_byte};
            wa_nxt            = '0;
            wl_nxt            = wl_dec;
            addr_nxt          = addr_step;
          end
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        if (in_bus.end_of_frame) begin
          if (!is_wr && (pos_r >= POS_W'(9))) begin
            wl_nxt          = cnt;
            push            = 1'b1;
            push_cmd.bytes  = {hb[9], hb[8], hb[7], hb[6], hb[5], hb[4], hb[3],
                               rlen[7:0], rlen[15:8], hb[0]};
            push_cmd.nbytes = BIDX_W'(HDR_BYTES);
            push_cmd.last   = (cnt == 16'd0);
            push_cmd.req    = (cnt != 16'd0);
            push_cmd.addr   = addr_r;
            if (cnt != 16'd0) begin
              phase_nxt = PH_WAIT;
            end
          end else begin
            wl_nxt = '0;
          end
          pos_nxt = '0;
          wa_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RECV;
      pos_r   <= '0;
      addr_r  <= '0;
      wa_r    <= '0;
      wl_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      addr_r  <= addr_nxt;
      wa_r    <= wa_nxt;
      wl_r    <= wl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[pos_r[BIDX_W-1:0]] <= in_bus.frame_byte;
    end
  end

endmodule

/* design/rafb_queue.sv */
// ----------------------------------------------------------------------------
// rafb_queue
// Small command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rafb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rafb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rafb_pkg::cmd_t head
);
  import rafb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/rafb_back.sv */
// ----------------------------------------------------------------------------
// rafb_back
// Expands queued commands into bus writes, read requests and response bytes.
// ----------------------------------------------------------------------------
module rafb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rafb_pkg::cmd_t q_head,
  output logic           pop,
  rafb_out_if.source     out_bus
);
  import rafb_pkg::*;

  cmd_t              cmd_r;
  logic              busy_r, busy_nxt;
  logic [BIDX_W-1:0] idx_r, idx_nxt;
  logic [BIDX_W-1:0] last_idx;
  logic              final_res;
  logic              out_acc;

  assign out_acc   = out_bus.valid && out_bus.ready;
  assign last_idx  = cmd_r.req ? cmd_r.nbytes : cmd_r.nbytes - BIDX_W'(1);
  assign final_res = cmd_r.is_write || (idx_r == last_idx);
  assign pop       = q_valid && (!busy_r || (out_acc && final_res));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_acc) begin
      if (final_res) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_head;
    end
  end

  always_comb begin
    out_bus.valid         = busy_r;
    out_bus.result_kind   = KIND_WRITE;
    out_bus.bus_address   = '0;
    out_bus.write_word    = '0;
    out_bus.response_byte = '0;
    out_bus.last          = 1'b0;
    if (cmd_r.is_write) begin
      out_bus.result_kind = KIND_WRITE;
      out_bus.bus_address = cmd_r.addr;
      out_bus.write_word  = cmd_r.word;
    end else if (idx_r < cmd_r.nbytes) begin
      out_bus.result_kind   = KIND_BYTE;
      out_bus.response_byte = cmd_r.bytes[idx_r];
      out_bus.last          = cmd_r.last && (idx_r == cmd_r.nbytes - BIDX_W'(1));
    end else begin
      out_bus.result_kind = KIND_READREQ;
      out_bus.bus_address = cmd_r.addr;
    end
  end

endmodule

/* design/register_access_frame_bridge.sv */
// ----------------------------------------------------------------------------
// register_access_frame_bridge
// Each result is registered in the command queue, then in the back end's command register.
// Throughput: one input transaction per cycle while the command queue has room;
// results leave one per cycle while ready (read frame end 10-11, read data 4-5).
// Reset: synchronous rst_n clears frame tracking, queue and output stage.
// ----------------------------------------------------------------------------
module register_access_frame_bridge #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  rafb_in_if.sink    in_bus,
  rafb_out_if.source out_bus
);
  import rafb_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t q_head;

  rafb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rafb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rafb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

/* design/rafb_checker.sv */
// ----------------------------------------------------------------------------
// rafb_checker
// Port level checks on the result channel of the frame bridge.
// ----------------------------------------------------------------------------
module rafb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [31:0] bus_address,
  input logic [31:0] write_word,
  input logic [7:0]  response_byte,
  input logic        last
);
  import rafb_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_last_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last |-> result_kind == KIND_BYTE)
    else $error("last flag on a non-byte result");

  a_word_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != KIND_WRITE |-> write_word == 32'd0)
    else $error("write data on a non-write result");

  a_byte_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_BYTE |-> bus_address == 32'd0)
    else $error("address on a response byte");

  a_bus_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != KIND_BYTE |-> response_byte == 8'd0)
    else $error("response byte on a bus transaction");

endmodule

bind register_access_frame_bridge rafb_checker u_rafb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .result_kind   (out_bus.result_kind),
  .bus_address   (out_bus.bus_address),
  .write_word    (out_bus.write_word),
  .response_byte (out_bus.response_byte),
  .last          (out_bus.last)
);
